@@ design/earliest_records_top_k_keeper_unit_macros.svh @@
`ifndef EARLIEST_RECORDS_TOP_K_KEEPER_UNIT_MACROS_SVH
`define EARLIEST_RECORDS_TOP_K_KEEPER_UNIT_MACROS_SVH

// check a condition in the same cycle
`define ERTK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ertk assertion failed");

// check a condition in the next cycle
`define ERTK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ertk assertion failed");

`endif

@@ design/ertk_pkg.sv @@
package ertk_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int KEEP_W = 5;
  localparam int POS_W  = 4;
  localparam int TIME_W = 64;
  localparam int TAG_W  = 32;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic drain_step;
  } cmd_t;

  typedef struct packed {
    logic drain_last;
  } stat_t;

endpackage

@@ design/ertk_ctrl.sv @@
module ertk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           mode,
  input  ertk_pkg::stat_t stat,
  output ertk_pkg::cmd_t  cmd,
  output logic           busy
);
  import ertk_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = mode ? ST_DRAIN : ST_INSERT;
        end
      end
      ST_INSERT: begin
        state_next = ST_IDLE;
      end
      ST_DRAIN: begin
        if (stat.drain_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
      end
      ST_DRAIN: begin
        cmd.drain_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ design/ertk_datapath.sv @@
`include "earliest_records_top_k_keeper_unit_macros.svh"

module ertk_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  ertk_pkg::cmd_t               cmd,
  output ertk_pkg::stat_t              stat,
  input  logic [ertk_pkg::TIME_W-1:0]  start_time,
  input  logic [ertk_pkg::TAG_W-1:0]   record_tag,
  input  logic                         cfg_valid,
  input  logic [ertk_pkg::KEEP_W-1:0]  cfg_data,
  output logic                         result_valid,
  output logic                         accepted,
  output logic [ertk_pkg::POS_W-1:0]   position,
  output logic [ertk_pkg::TIME_W-1:0]  out_time,
  output logic [ertk_pkg::TAG_W-1:0]   out_tag,
  output logic                         entry_valid,
  output logic                         last
);
  import ertk_pkg::*;

  logic [KEEP_W-1:0] keep_q;
  logic [CNT_W-1:0]  held_count;
  logic [IDX_W-1:0]  idx;
  logic [TIME_W-1:0] times [DEPTH];
  logic [TAG_W-1:0]  tags  [DEPTH];
  logic [TIME_W-1:0] t_q;
  logic [TAG_W-1:0]  tag_q;

  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  scan;
  logic [DEPTH-1:0]  gt;
  logic              found;
  logic              acc;
  logic [IDX_W-1:0]  p;
  logic [IDX_W-1:0]  top;
  logic              scan_zero;
  logic              drain_last;

  always_comb begin
    limit = (32'(keep_q) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(keep_q);
    scan  = (held_count < limit) ? held_count : limit;
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) < scan) && (times[i] > t_q);
    end
    found = 1'b0;
    p     = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (gt[i]) begin
        found = 1'b1;
        p     = IDX_W'(i);
      end
    end
    acc = 1'b1;
    if (!found) begin
      if (held_count < limit) begin
        p = IDX_W'(held_count);
      end else begin
        acc = 1'b0;
      end
    end
    top        = (held_count < CNT_W'(DEPTH)) ? IDX_W'(held_count) : IDX_W'(DEPTH - 1);
    scan_zero  = (scan == '0);
    drain_last = scan_zero || ((CNT_W'(idx) + CNT_W'(1)) == scan);
  end

  assign stat.drain_last = drain_last;

  // table cells: shift up behind the insert slot, shift down while draining
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_q   <= start_time;
      tag_q <= record_tag;
    end
    if (cmd.insert && acc) begin
      for (int j = 1; j < DEPTH; j++) begin
        if ((IDX_W'(j) > p) && (IDX_W'(j) <= top)) begin
          times[j] <= times[j-1];
          tags[j]  <= tags[j-1];
        end
      end
      for (int j = 0; j < DEPTH; j++) begin
        if (IDX_W'(j) == p) begin
          times[j] <= t_q;
          tags[j]  <= tag_q;
        end
      end
    end else if (cmd.drain_step) begin
      for (int j = 0; j < DEPTH - 1; j++) begin
        times[j] <= times[j+1];
        tags[j]  <= tags[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_q       <= KEEP_RESET;
      held_count   <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        keep_q <= cfg_data;
      end
      result_valid <= cmd.insert || cmd.drain_step;
      if (cmd.load) begin
        idx <= '0;
      end else if (cmd.drain_step) begin
        idx <= idx + IDX_W'(1);
      end
      if (cmd.insert && acc) begin
        held_count <= (held_count < CNT_W'(DEPTH)) ? held_count + CNT_W'(1) : CNT_W'(DEPTH);
      end else if (cmd.drain_step && drain_last) begin
        held_count <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      accepted    <= acc;
      position    <= acc ? POS_W'(p) : '0;
      out_time    <= '0;
      out_tag     <= '0;
      entry_valid <= 1'b0;
      last        <= 1'b1;
    end else if (cmd.drain_step) begin
      accepted    <= 1'b0;
      position    <= scan_zero ? '0 : POS_W'(idx);
      out_time    <= scan_zero ? '0 : times[0];
      out_tag     <= scan_zero ? '0 : tags[0];
      entry_valid <= !scan_zero;
      last        <= drain_last;
    end
  end

  `ERTK_ASSERT_NOW(a_count_bound, 1'b1, held_count <= CNT_W'(DEPTH))
  `ERTK_ASSERT_NEXT(a_drain_clears, cmd.drain_step && drain_last, held_count == '0)
  `ERTK_ASSERT_NEXT(a_insert_grows, cmd.insert && acc && (held_count < CNT_W'(DEPTH)),
    held_count == CNT_W'($past(held_count) + CNT_W'(1)))

endmodule

@@ design/earliest_records_top_k_keeper_unit.sv @@
// Keeps the keep_count records (at most DEPTH = 16) with the earliest
// start_time, sorted ascending (equal times in arrival order). An insert
// (mode 0) captures the item, then makes one compare-and-shift pass over all
// table slots in parallel; its single result is strobed on result_valid in
// the cycle after that pass. A drain (mode 1) emits one result per held
// record (a single result with entry_valid low when the table is empty): slot
// 0 of the table is emitted and the table shifts down by one slot each cycle.
// Results appear for exactly one cycle and cannot be stalled; a new item may be
// started in the same cycle that the previous item's final result is shown.
// keep_count may be written only while busy is low and no result is pending.
module earliest_records_top_k_keeper_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         mode,
  input  logic [ertk_pkg::TIME_W-1:0]  start_time,
  input  logic [ertk_pkg::TAG_W-1:0]   record_tag,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ertk_pkg::KEEP_W-1:0]  cfg_data,
  output logic                         result_valid,
  output logic                         accepted,
  output logic [ertk_pkg::POS_W-1:0]   position,
  output logic [ertk_pkg::TIME_W-1:0]  out_time,
  output logic [ertk_pkg::TAG_W-1:0]   out_tag,
  output logic                         entry_valid,
  output logic                         last
);
  import ertk_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ertk_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  ertk_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .start_time   (start_time),
    .record_tag   (record_tag),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .accepted     (accepted),
    .position     (position),
    .out_time     (out_time),
    .out_tag      (out_tag),
    .entry_valid  (entry_valid),
    .last         (last)
  );

endmodule
